@@ rtl/psaf_pkg.sv @@
// psaf_pkg: shared types and constants of the per-source attack filter
`timescale 1ns / 1ps
package psaf_pkg;

  localparam logic [31:0] LOOPBACK_WORD = 32'h0100_007F;

  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    REG_SYN_WINDOW = 3'd0,
    REG_SYN_THRESH = 3'd1,
    REG_SSH_WINDOW = 3'd2,
    REG_SSH_THRESH = 3'd3,
    REG_SSH_PORT   = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_SYN      = 2'd1;
  localparam logic [1:0] EV_SSH      = 2'd2;
  localparam logic [1:0] EV_NEW_CONN = 2'd3;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic        is_host_packet;
    logic        is_tcp;
    logic        syn_flag;
    logic        ack_flag;
    logic        rst_flag;
    logic [15:0] dst_port;
    logic [31:0] now_sec;
  } in_t;

  typedef struct packed {
    logic       drop;
    logic [1:0] event_res;
    logic       untracked;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] now;
    logic        skip;
    logic        tcp;
    logic        pure_syn;
    logic        ssh_hit;
    logic        new_conn;
  } cls_t;

  typedef struct packed {
    logic        bl;
    logic [31:0] syn_start;
    logic [15:0] syn_cnt;
    logic [31:0] ssh_start;
    logic [15:0] ssh_cnt;
  } ent_t;

  typedef struct packed {
    logic [15:0] syn_win;
    logic [15:0] syn_thr;
    logic [15:0] ssh_win;
    logic [15:0] ssh_thr;
    logic [15:0] guard_port;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EXEC
  } back_st_t;

endpackage

@@ rtl/psaf_front.sv @@
// psaf_front: request intake, classification and two-entry queue
`timescale 1ns / 1ps
module psaf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  psaf_pkg::in_t   in_data,
  input  logic [15:0]     guard_port,
  output logic            q_valid,
  output psaf_pkg::cls_t  q_head,
  input  logic            q_pop
);

  psaf_pkg::cls_t q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  psaf_pkg::cls_t cls;

  always_comb begin
    cls.src      = in_data.src_ip;
    cls.now      = in_data.now_sec;
    cls.skip     = (in_data.src_ip == in_data.dst_ip) || !in_data.is_host_packet ||
                   (in_data.src_ip == 32'd0) || (in_data.src_ip == psaf_pkg::LOOPBACK_WORD);
    cls.tcp      = in_data.is_tcp;
    cls.pure_syn = in_data.syn_flag && !in_data.ack_flag && !in_data.rst_flag;
    cls.new_conn = in_data.syn_flag && !in_data.ack_flag;
    cls.ssh_hit  = !(in_data.syn_flag && !in_data.ack_flag) && (in_data.dst_port == guard_port);
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

@@ rtl/psaf_back.sv @@
// psaf_back: source table scan, counter update and result register
`timescale 1ns / 1ps
module psaf_back #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  psaf_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  psaf_pkg::cls_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output psaf_pkg::out_t  out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  logic [31:0]        key_mem [TABLE_ENTRIES];
  psaf_pkg::ent_t     ent_mem [TABLE_ENTRIES];

  psaf_pkg::back_st_t st_r, st_nxt;
  logic [IW:0]        fill_r, fill_nxt;
  logic [IW:0]        scan_r, scan_nxt;
  logic               found_r, found_nxt;
  logic [31:0]        key_rd_r;
  psaf_pkg::ent_t     ent_rd_r;
  logic               out_valid_r, out_valid_nxt;
  psaf_pkg::out_t     out_r;

  logic               key_match, last_slot, commit, out_free;
  logic               act, expired, hit, do_insert, do_update;
  logic [31:0]        old_start, delta;
  logic [15:0]        win, thr, cnt, cnt_inc;
  psaf_pkg::ent_t     ent_new;
  psaf_pkg::out_t     res;

  assign key_match = (key_rd_r == q_head.src);
  assign last_slot = ((scan_r + 1'b1) == fill_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (st_r == psaf_pkg::ST_EXEC) && out_free;
  assign q_pop     = commit;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      psaf_pkg::ST_IDLE: begin
        if (q_valid) begin
          st_nxt = (q_head.skip || fill_r == '0) ? psaf_pkg::ST_EXEC : psaf_pkg::ST_READ;
        end
      end
      psaf_pkg::ST_READ: st_nxt = psaf_pkg::ST_CMP;
      psaf_pkg::ST_CMP: begin
        st_nxt = (key_match || last_slot) ? psaf_pkg::ST_EXEC : psaf_pkg::ST_READ;
      end
      psaf_pkg::ST_EXEC: begin
        if (out_free) begin
          st_nxt = psaf_pkg::ST_IDLE;
        end
      end
      default: st_nxt = psaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    old_start = q_head.pure_syn ? ent_rd_r.syn_start : ent_rd_r.ssh_start;
    win       = q_head.pure_syn ? cfg.syn_win : cfg.ssh_win;
    thr       = q_head.pure_syn ? cfg.syn_thr : cfg.ssh_thr;
    cnt       = q_head.pure_syn ? ent_rd_r.syn_cnt : ent_rd_r.ssh_cnt;
    delta     = q_head.now - old_start;
    expired   = (delta >= {16'd0, win});
    cnt_inc   = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
    hit       = !expired && (cnt_inc >= thr);
    act       = !q_head.skip && q_head.tcp && (q_head.pure_syn || q_head.ssh_hit);

    res           = '0;
    do_insert     = 1'b0;
    do_update     = 1'b0;
    ent_new       = ent_rd_r;
    if (!q_head.skip) begin
      if (found_r && ent_rd_r.bl) begin
        res.drop = 1'b1;
      end else if (q_head.tcp) begin
        if (act) begin
          if (!found_r) begin
            if (fill_r < TABLE_ENTRIES[IW:0]) begin
              do_insert = 1'b1;
            end else begin
              res.untracked = 1'b1;
            end
          end else begin
            do_update = 1'b1;
            if (hit) begin
              ent_new.bl    = 1'b1;
              res.drop      = 1'b1;
              res.event_res = q_head.pure_syn ? psaf_pkg::EV_SYN : psaf_pkg::EV_SSH;
            end
          end
        end
        if (!res.drop && q_head.new_conn) begin
          res.event_res = psaf_pkg::EV_NEW_CONN;
        end
      end
    end

    if (do_insert) begin
      ent_new.bl        = 1'b0;
      ent_new.syn_start = q_head.now;
      ent_new.ssh_start = q_head.now;
      ent_new.syn_cnt   = q_head.pure_syn ? 16'd1 : 16'd0;
      ent_new.ssh_cnt   = q_head.pure_syn ? 16'd0 : 16'd1;
    end else if (q_head.pure_syn) begin
      ent_new.syn_cnt   = expired ? 16'd0 : cnt_inc;
      ent_new.syn_start = expired ? q_head.now : old_start;
    end else begin
      ent_new.ssh_cnt   = expired ? 16'd0 : cnt_inc;
      ent_new.ssh_start = expired ? q_head.now : old_start;
    end
  end

  always_comb begin
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (st_r)
      psaf_pkg::ST_IDLE: begin
        scan_nxt  = '0;
        found_nxt = 1'b0;
      end
      psaf_pkg::ST_CMP: begin
        found_nxt = key_match;
        if (!key_match && !last_slot) begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      psaf_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (do_insert) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= psaf_pkg::ST_IDLE;
      fill_r      <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == psaf_pkg::ST_READ) begin
      key_rd_r <= key_mem[scan_r[IW-1:0]];
      ent_rd_r <= ent_mem[scan_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (commit && do_insert) begin
      key_mem[fill_r[IW-1:0]] <= q_head.src;
      ent_mem[fill_r[IW-1:0]] <= ent_new;
    end else if (commit && do_update) begin
      ent_mem[scan_r[IW-1:0]] <= ent_new;
    end
  end

endmodule

@@ rtl/per_source_attack_filter_core.sv @@
// per_source_attack_filter_core: top level of the per-source attack filter
// flow: the back end scans filled table slots in turn (read state, then compare state)
//   per slot, until a match (or all filled slots on a miss); a skipped request or an
//   empty table goes straight to the result state, which waits while a stalled result
//   is held; one request is worked at a time, with a two-entry queue in front
// reset: synchronous active low; clears queue, fill count and output valid, loads defaults
`timescale 1ns / 1ps
module per_source_attack_filter_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  psaf_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output psaf_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [psaf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [15:0]                 cfg_wdata
);

  psaf_pkg::cfg_t cfg_r;
  logic           q_valid, q_pop;
  psaf_pkg::cls_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.syn_win    <= 16'd10;
      cfg_r.syn_thr    <= 16'd100;
      cfg_r.ssh_win    <= 16'd60;
      cfg_r.ssh_thr    <= 16'd20;
      cfg_r.guard_port <= 16'd22;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        psaf_pkg::REG_SYN_WINDOW: cfg_r.syn_win    <= cfg_wdata;
        psaf_pkg::REG_SYN_THRESH: cfg_r.syn_thr    <= cfg_wdata;
        psaf_pkg::REG_SSH_WINDOW: cfg_r.ssh_win    <= cfg_wdata;
        psaf_pkg::REG_SSH_THRESH: cfg_r.ssh_thr    <= cfg_wdata;
        psaf_pkg::REG_SSH_PORT:   cfg_r.guard_port <= cfg_wdata;
        default: ;
      endcase
    end
  end

  psaf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .guard_port (cfg_r.guard_port),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  psaf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/psaf_checker.sv @@
// psaf_checker: port-level assertions for the per-source attack filter
`timescale 1ns / 1ps
module psaf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input psaf_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_attack_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == psaf_pkg::EV_SYN ||
                  out_data.event_res == psaf_pkg::EV_SSH) |-> out_data.drop)
    else $error("attack event without drop");

  a_untracked_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.untracked ||
                  out_data.event_res == psaf_pkg::EV_NEW_CONN) |-> !out_data.drop)
    else $error("dropped untracked or new connection request");

endmodule

bind per_source_attack_filter_core psaf_checker u_psaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ dv/per_source_attack_filter_core_tb.sv @@
// per_source_attack_filter_core_tb: self-checking testbench of the per-source attack filter
`timescale 1ns / 1ps
module per_source_attack_filter_core_tb;

  localparam int NSLOT = 256;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [psaf_pkg::CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam logic [psaf_pkg::CFG_AW-1:0] REG_SPARE = 3'd5;
  localparam logic [31:0] POOL_BASE = 32'h0A00_0001;
  localparam logic [31:0] FILL_BASE = 32'hC0A8_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  psaf_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  psaf_pkg::out_t out_data;
  logic cfg_we;
  logic [psaf_pkg::CFG_AW-1:0] cfg_addr;
  logic [15:0] cfg_wdata;

  per_source_attack_filter_core #(.TABLE_ENTRIES(NSLOT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // filter state mirror
  logic [15:0] syn_win, syn_thr, ssh_win, ssh_thr, guard_port_r;
  bit slot_used [NSLOT];
  logic [31:0] slot_src [NSLOT];
  bit slot_bl [NSLOT];
  logic [31:0] slot_syn_t0 [NSLOT];
  logic [15:0] slot_syn_n [NSLOT];
  logic [31:0] slot_ssh_t0 [NSLOT];
  logic [15:0] slot_ssh_n [NSLOT];

  psaf_pkg::out_t verdict_q [$];
  int mismatches = 0;
  int cycles = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_cnt = 0;
  logic [31:0] clock_s = 32'hFFFF_FFF0;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver back-pressure
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt = hold_cnt - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    psaf_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected verdict: expected none actual %p", $time, out_data);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.drop !== want.drop) begin
          mismatches++;
          $display("%0t drop: expected %0d actual %0d", $time, want.drop, out_data.drop);
        end
        if (out_data.event_res !== want.event_res) begin
          mismatches++;
          $display("%0t event_res: expected %0d actual %0d", $time, want.event_res,
                   out_data.event_res);
        end
        if (out_data.untracked !== want.untracked) begin
          mismatches++;
          $display("%0t untracked: expected %0d actual %0d", $time, want.untracked,
                   out_data.untracked);
        end
      end
    end
  end

  function automatic bit add_source(logic [31:0] src, logic [31:0] now, bit is_ssh);
    for (int i = 0; i < NSLOT; i++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_src[i] = src;
        slot_bl[i] = 1'b0;
        slot_syn_t0[i] = now;
        slot_ssh_t0[i] = now;
        slot_syn_n[i] = is_ssh ? 16'd0 : 16'd1;
        slot_ssh_n[i] = is_ssh ? 16'd1 : 16'd0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic bump_count(inout logic [15:0] n, inout logic [31:0] t0,
                            input logic [31:0] now, input logic [15:0] win,
                            input logic [15:0] thr, output bit hit);
    logic [31:0] age;
    age = now - t0;
    hit = 1'b0;
    if (age >= {16'h0, win}) begin
      n = 16'd0;
      t0 = now;
    end else begin
      if (n != 16'hFFFF) n = n + 16'd1;
      hit = (n >= thr);
    end
  endtask

  task automatic judge_packet(input psaf_pkg::in_t p, output psaf_pkg::out_t v);
    int s;
    bit hit;
    bit syn_noack;
    v = '0;
    s = -1;
    if (p.src_ip == p.dst_ip || !p.is_host_packet || p.src_ip == 32'h0
        || p.src_ip == psaf_pkg::LOOPBACK_WORD) return;
    for (int i = 0; i < NSLOT; i++) begin
      if (s < 0 && slot_used[i] && slot_src[i] == p.src_ip) s = i;
    end
    if (s >= 0 && slot_bl[s]) begin
      v.drop = 1'b1;
      return;
    end
    if (!p.is_tcp) return;
    syn_noack = p.syn_flag && !p.ack_flag;
    if (syn_noack && !p.rst_flag) begin
      if (s < 0) begin
        if (!add_source(p.src_ip, p.now_sec, 1'b0)) v.untracked = 1'b1;
      end else begin
        bump_count(slot_syn_n[s], slot_syn_t0[s], p.now_sec, syn_win, syn_thr, hit);
        if (hit) begin
          slot_bl[s] = 1'b1;
          v.drop = 1'b1;
          v.event_res = psaf_pkg::EV_SYN;
        end
      end
    end
    if (!v.drop && !syn_noack && p.dst_port == guard_port_r) begin
      if (s < 0) begin
        if (!add_source(p.src_ip, p.now_sec, 1'b1)) v.untracked = 1'b1;
      end else begin
        bump_count(slot_ssh_n[s], slot_ssh_t0[s], p.now_sec, ssh_win, ssh_thr, hit);
        if (hit) begin
          slot_bl[s] = 1'b1;
          v.drop = 1'b1;
          v.event_res = psaf_pkg::EV_SSH;
        end
      end
    end
    if (!v.drop && syn_noack) v.event_res = psaf_pkg::EV_NEW_CONN;
  endtask

  function automatic psaf_pkg::in_t pkt(logic [31:0] src, logic [31:0] dst, bit host,
                                        bit tcp, bit syn, bit ack, bit rst,
                                        logic [15:0] port, logic [31:0] now);
    psaf_pkg::in_t p;
    p.src_ip = src;
    p.dst_ip = dst;
    p.is_host_packet = host;
    p.is_tcp = tcp;
    p.syn_flag = syn;
    p.ack_flag = ack;
    p.rst_flag = rst;
    p.dst_port = port;
    p.now_sec = now;
    return p;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_req(input psaf_pkg::in_t p);
    psaf_pkg::out_t v;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = p;
    do @(posedge clk); while (in_stall);
    judge_packet(p, v);
    verdict_q.push_back(v);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [psaf_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      psaf_pkg::REG_SYN_WINDOW: syn_win = val;
      psaf_pkg::REG_SYN_THRESH: syn_thr = val;
      psaf_pkg::REG_SSH_WINDOW: ssh_win = val;
      psaf_pkg::REG_SSH_THRESH: ssh_thr = val;
      psaf_pkg::REG_SSH_PORT:   guard_port_r = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] sw, logic [15:0] st, logic [15:0] hw,
                         logic [15:0] ht, logic [15:0] port);
    drain();
    write_reg(psaf_pkg::REG_SYN_WINDOW, sw);
    write_reg(psaf_pkg::REG_SYN_THRESH, st);
    write_reg(psaf_pkg::REG_SSH_WINDOW, hw);
    write_reg(psaf_pkg::REG_SSH_THRESH, ht);
    write_reg(psaf_pkg::REG_SSH_PORT, port);
  endtask

  function automatic psaf_pkg::in_t rand_pkt(logic [31:0] pool);
    logic [31:0] src;
    int kind;
    if ($urandom_range(99) < 90) clock_s = clock_s + $urandom_range(0, 2);
    else clock_s = clock_s + $urandom_range(0, 200);
    if ($urandom_range(99) < 1) clock_s = clock_s + $urandom;
    src = pool + $urandom_range(0, 7);
    kind = $urandom_range(99);
    if (kind < 10)
      return pkt($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 16'($urandom), $urandom);
    if (kind < 55)
      return pkt(src, $urandom, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'($urandom), clock_s);
    if (kind < 90)
      return pkt(src, $urandom, 1'b1, 1'b1, 1'($urandom_range(1)), 1'b1,
                 1'($urandom_range(1)), guard_port_r, clock_s);
    return pkt(src, $urandom, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom_range(1) ? guard_port_r : 16'($urandom), clock_s);
  endfunction

  task automatic test_directed;
    logic [31:0] a;
    a = 32'h2000_0001;
    send_req(pkt(a, a, 1, 1, 1, 0, 0, 22, 32'd5));
    send_req(pkt(a, 32'h0, 0, 1, 1, 0, 0, 22, 32'd5));
    send_req(pkt(32'h0, a, 1, 1, 1, 0, 0, 22, 32'd5));
    send_req(pkt(psaf_pkg::LOOPBACK_WORD, a, 1, 1, 1, 0, 0, 22, 32'd5));
    send_req(pkt(32'hFFFF_FFFF, 32'h0, 1, 0, 1, 1, 1, 16'hFFFF, 32'hFFFF_FFFF));
    send_req(pkt(a, 32'hFFFF_FFFF, 1, 1, 1, 0, 0, 16'h0, 32'd0));
    send_req(pkt(a, 32'h1, 1, 1, 1, 0, 1, 22, 32'd1));
    send_req(pkt(a, 32'h1, 1, 1, 1, 1, 0, 22, 32'd1));
    send_req(pkt(a, 32'h1, 1, 1, 0, 1, 0, 22, 32'd2));
    send_req(pkt(a + 1, 32'h1, 1, 1, 0, 1, 0, 22, 32'd2));
    send_req(pkt(a + 2, 32'h1, 1, 1, 0, 0, 1, 16'hFFFF, 32'd2));
    send_req(pkt(a + 2, 32'h1, 1, 1, 1, 0, 0, 16'h0, 32'd100));
    send_req(pkt(a + 1, 32'h1, 1, 0, 1, 0, 0, 22, 32'd3));
    drain();
  endtask

  task automatic test_syn_flood;
    logic [31:0] a;
    a = 32'h3000_0001;
    set_all(16'd5, 16'd3, 16'd60, 16'd20, 16'd22);
    for (int i = 0; i < 8; i++) send_req(pkt(a, 32'h9, 1, 1, 1, 0, 0, 80, 32'd10 + i));
    send_req(pkt(a + 1, 32'h9, 1, 1, 1, 0, 0, 80, 32'd100));
    send_req(pkt(a + 1, 32'h9, 1, 1, 1, 0, 0, 80, 32'd101));
    send_req(pkt(a + 1, 32'h9, 1, 1, 1, 0, 0, 80, 32'd110));
    send_req(pkt(a + 1, 32'h9, 1, 1, 1, 0, 0, 80, 32'd111));
    drain();
  endtask

  task automatic test_ssh_brute;
    logic [31:0] a;
    a = 32'h4000_0001;
    set_all(16'd10, 16'd100, 16'd1, 16'd2, 16'hFFFF);
    send_req(pkt(a, 32'h9, 1, 1, 0, 1, 0, 16'hFFFF, 32'd7));
    send_req(pkt(a, 32'h9, 1, 1, 0, 1, 0, 16'hFFFF, 32'd8));
    send_req(pkt(a, 32'h9, 1, 1, 0, 1, 0, 16'hFFFF, 32'd8));
    send_req(pkt(a, 32'h9, 1, 1, 0, 1, 0, 16'hFFFF, 32'd8));
    set_all(16'd10, 16'd100, 16'hFFFF, 16'd3, 16'h0);
    for (int i = 0; i < 5; i++) send_req(pkt(a + 1, 32'h9, 1, 1, i[0], 1, i[1], 16'h0, 32'd50));
    drain();
  endtask

  task automatic test_config_extremes;
    logic [31:0] a;
    a = 32'h5000_0001;
    set_all(16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'd22);
    send_req(pkt(a, 32'h9, 1, 1, 1, 0, 0, 22, 32'hFFFF_FF00));
    send_req(pkt(a, 32'h9, 1, 1, 1, 0, 0, 22, 32'h0000_0100));
    send_req(pkt(a + 1, 32'h9, 1, 1, 0, 1, 0, 22, 32'd0));
    send_req(pkt(a + 1, 32'h9, 1, 1, 0, 1, 0, 22, 32'd65535));
    send_req(pkt(a + 1, 32'h9, 1, 1, 0, 1, 0, 22, 32'd65536));
    drain();
    write_reg(REG_UNUSED, 16'h1234);
    write_reg(REG_SPARE, 16'hFFFF);
    set_all(16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd22);
    for (int i = 0; i < 4; i++) send_req(pkt(a + 2, 32'h9, 1, 1, 1, 0, 0, 22, 32'd9));
    drain();
  endtask

  task automatic test_random;
    logic [31:0] pool;
    pool = POOL_BASE;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 48; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 48; end
        default: begin send_gap_pct = 14; stall_pct = 14; end
      endcase
      set_all(16'($urandom_range(1, 20)), 16'($urandom_range(2, 15)),
              16'($urandom_range(1, 30)), 16'($urandom_range(2, 10)),
              $urandom_range(1) ? 16'd22 : 16'($urandom));
      for (int i = 0; i < 200; i++) begin
        if (i % 100 == 0) pool = pool + 32'd16;
        send_req(rand_pkt(pool));
      end
    end
    send_gap_pct = 0;
    stall_pct = 0;
    drain();
  endtask

  task automatic test_backpressure;
    hold_cnt = 400;
    for (int i = 0; i < 40; i++) send_req(rand_pkt(POOL_BASE + 32'd16));
    drain();
  endtask

  task automatic test_table_full;
    int k;
    int used;
    k = 0;
    send_gap_pct = 14;
    stall_pct = 14;
    do begin
      send_req(pkt(FILL_BASE + k, 32'h9, 1, 1, 1, 0, 0, 80, clock_s));
      k++;
      used = 0;
      foreach (slot_used[i]) used += slot_used[i];
    end while (used < NSLOT);
    for (int i = 0; i < 30; i++) begin
      case (i % 3)
        0: send_req(pkt(FILL_BASE + k + i, 32'h9, 1, 1, 1, 0, 0, 80, clock_s));
        1: send_req(pkt(FILL_BASE + k + i, 32'h9, 1, 1, 0, 1, 0, guard_port_r, clock_s));
        default: send_req(pkt(FILL_BASE + $urandom_range(0, k - 1), 32'h9, 1, 1,
                              1, 0, 0, 80, clock_s + 1));
      endcase
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    syn_win = 16'd10;
    syn_thr = 16'd100;
    ssh_win = 16'd60;
    ssh_thr = 16'd20;
    guard_port_r = 16'd22;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_syn_flood();
    test_ssh_brute();
    test_config_extremes();
    test_random();
    test_backpressure();
    test_table_full();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/psaf_pkg.sv
rtl/psaf_front.sv
rtl/psaf_back.sv
rtl/per_source_attack_filter_core.sv
rtl/psaf_checker.sv
dv/per_source_attack_filter_core_tb.sv
